[hw/rtl/morse_code_codec_defines.svh]
// Assertion helpers for the checker file.
`ifndef MORSE_CODE_CODEC_DEFINES_SVH
`define MORSE_CODE_CODEC_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define MCC_ASSERT_NOW(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
    else $error("morse_code_codec: same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define MCC_ASSERT_NEXT(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
    else $error("morse_code_codec: next-cycle check failed");

`endif

[hw/rtl/mcc_pkg.sv]
`default_nettype none

package mcc_pkg;

  localparam int TABLE_SIZE = 48;
  localparam int SYM_W      = 9;
  localparam int IDX_W      = 6;

  localparam logic [7:0] FIRST_CHAR  = 8'd43;   // '+'
  localparam logic [7:0] LAST_CHAR   = 8'd90;   // 'Z'
  localparam logic [7:0] LOWER_A     = 8'd97;
  localparam logic [7:0] LOWER_Z     = 8'd122;
  localparam logic [7:0] CASE_OFFSET = 8'd32;
  localparam logic [7:0] CH_SPACE    = 8'd32;
  localparam logic [7:0] CH_SLASH    = 8'd47;
  localparam logic [7:0] CH_ZERO     = 8'd48;
  localparam logic [7:0] CH_ONE      = 8'd49;
  localparam logic [7:0] CH_NUL      = 8'd0;

  // Code value per table entry, first symbol in the most significant used bit.
  localparam logic [SYM_W-1:0] SYM_VALUE [TABLE_SIZE] = '{
    9'd10, 9'd2,  9'd0,  9'd21, 9'd18, 9'd31, 9'd15, 9'd7,  9'd3,  9'd1,
    9'd0,  9'd16, 9'd24, 9'd28, 9'd30, 9'd21, 9'd56, 9'd8,  9'd17, 9'd5,
    9'd12, 9'd26, 9'd1,  9'd8,  9'd10, 9'd4,  9'd0,  9'd2,  9'd6,  9'd0,
    9'd0,  9'd7,  9'd5,  9'd4,  9'd3,  9'd2,  9'd7,  9'd6,  9'd13, 9'd2,
    9'd0,  9'd1,  9'd1,  9'd1,  9'd3,  9'd9,  9'd11, 9'd12
  };

  // Code length in symbols per table entry.
  localparam logic [3:0] SYM_LENGTH [TABLE_SIZE] = '{
    4'd5, 4'd5, 4'd8, 4'd6, 4'd5, 4'd5, 4'd5, 4'd5, 4'd5, 4'd5,
    4'd5, 4'd5, 4'd5, 4'd5, 4'd5, 4'd5, 4'd9, 4'd5, 4'd5, 4'd6,
    4'd6, 4'd6, 4'd2, 4'd4, 4'd4, 4'd3, 4'd1, 4'd4, 4'd3, 4'd4,
    4'd2, 4'd4, 4'd3, 4'd4, 4'd2, 4'd2, 4'd3, 4'd4, 4'd4, 4'd3,
    4'd3, 4'd1, 4'd3, 4'd4, 4'd3, 4'd4, 4'd4, 4'd4
  };

  typedef struct packed {
    logic [7:0] ch;
    logic       err;
  } res_t;

  // Result list for one item: sym_cnt symbols from sym_val, then tail_cnt tails.
  typedef struct packed {
    logic [SYM_W-1:0] sym_val;
    logic [3:0]       sym_cnt;
    res_t             tail0;
    res_t             tail1;
    logic [1:0]       tail_cnt;
  } burst_t;

endpackage

`default_nettype wire

[hw/rtl/mcc_emit.sv]
`default_nettype none

module mcc_emit import mcc_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       load,
  input  wire burst_t     desc,
  output logic            ready,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_char,
  output logic            out_code_error,
  output logic            out_last
);

  logic [SYM_W-1:0] sym_val_r, sym_val_nxt;
  logic [3:0]       sym_cnt_r, sym_cnt_nxt;
  res_t             tail0_r, tail0_nxt;
  res_t             tail1_r, tail1_nxt;
  logic [1:0]       tail_cnt_r, tail_cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_char_r, out_char_nxt;
  logic             out_err_r, out_err_nxt;
  logic             out_last_r, out_last_nxt;

  logic       take;
  logic       busy;
  logic       one_left;
  logic [3:0] bit_sel;

  assign take     = !out_valid_r || !out_stall;
  assign busy     = (sym_cnt_r != 4'd0) || (tail_cnt_r != 2'd0);
  assign one_left = ((sym_cnt_r == 4'd0) && (tail_cnt_r == 2'd1)) ||
                    ((sym_cnt_r == 4'd1) && (tail_cnt_r == 2'd0));
  assign ready    = !busy || (take && one_left);
  assign bit_sel  = sym_cnt_r - 4'd1;

  always_comb begin
    sym_val_nxt   = sym_val_r;
    sym_cnt_nxt   = sym_cnt_r;
    tail0_nxt     = tail0_r;
    tail1_nxt     = tail1_r;
    tail_cnt_nxt  = tail_cnt_r;
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_err_nxt   = out_err_r;
    out_last_nxt  = out_last_r;
    if (take) begin
      out_valid_nxt = busy;
      if (sym_cnt_r != 4'd0) begin
        out_char_nxt = sym_val_r[bit_sel] ? CH_ONE : CH_ZERO;
        out_err_nxt  = 1'b0;
        out_last_nxt = (sym_cnt_r == 4'd1) && (tail_cnt_r == 2'd0);
        sym_cnt_nxt  = sym_cnt_r - 4'd1;
      end else if (tail_cnt_r != 2'd0) begin
        out_char_nxt = tail0_r.ch;
        out_err_nxt  = tail0_r.err;
        out_last_nxt = (tail_cnt_r == 2'd1);
        tail0_nxt    = tail1_r;
        tail_cnt_nxt = tail_cnt_r - 2'd1;
      end
    end
    // ready guarantees the old list is gone or leaving this cycle
    if (load) begin
      sym_val_nxt  = desc.sym_val;
      sym_cnt_nxt  = desc.sym_cnt;
      tail0_nxt    = desc.tail0;
      tail1_nxt    = desc.tail1;
      tail_cnt_nxt = desc.tail_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sym_cnt_r   <= 4'd0;
      tail_cnt_r  <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      sym_cnt_r   <= sym_cnt_nxt;
      tail_cnt_r  <= tail_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    sym_val_r  <= sym_val_nxt;
    tail0_r    <= tail0_nxt;
    tail1_r    <= tail1_nxt;
    out_char_r <= out_char_nxt;
    out_err_r  <= out_err_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_char       = out_char_r;
  assign out_code_error = out_err_r;
  assign out_last       = out_last_r;

endmodule

`default_nettype wire

[hw/rtl/morse_code_codec.sv]
// Morse code codec over a 48-entry table from '+' to 'Z'. With cfg mode 1 it
// encodes: each character (lowercase folded to upper) becomes its dots '0' and
// dashes '1' followed by ' '; a character outside the table becomes '/' then
// ' '. With mode 0 it decodes: '0'/'1' symbols are collected, a space or
// end_of_message with symbols pending emits the matching character, '/' emits
// a space, and an unknown or overlong code emits one result with code_error
// set and out_char 0. out_last marks the final result of each input transfer.
// Rate: every transfer is taken into a result list and then drained by the
// output serializer at one result per cycle while out_stall is low; in_stall
// holds the input until the list has only its last result left and the output
// can take it. Decode runs one symbol per cycle while the serializer is not
// busy. The first result goes through the result-list registers and then the
// output registers. Write cfg only while idle; pending decode symbols survive
// a mode change.

`default_nettype none

module morse_code_codec import mcc_pkg::*; #(
  parameter int MAX_CODE_BITS = 9
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_wr_en,
  input  wire logic       cfg_wr_data,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_char,
  input  wire logic       in_end_of_message,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_char,
  output logic            out_code_error,
  output logic            out_last
);

  localparam int CNT_W = $clog2(MAX_CODE_BITS + 1);

  // Mode register and decode collection state.
  logic                     mode_r;
  logic [MAX_CODE_BITS-1:0] code_bits_r, code_bits_nxt;
  logic [CNT_W-1:0]         code_count_r, code_count_nxt;
  logic                     code_ovf_r, code_ovf_nxt;

  logic   emit_ready;
  logic   accept;
  logic   load;
  burst_t enc_desc;
  burst_t dec_desc;
  burst_t desc;

  // Encode path: fold case, check table range, read the code.
  logic [7:0]       enc_ch;
  logic [7:0]       enc_off;
  logic [IDX_W-1:0] enc_idx;
  logic             enc_hit;

  always_comb begin
    enc_ch = in_char;
    if (in_char inside {[LOWER_A:LOWER_Z]}) begin
      enc_ch = in_char - CASE_OFFSET;
    end
    enc_hit = enc_ch inside {[FIRST_CHAR:LAST_CHAR]};
    enc_off = enc_ch - FIRST_CHAR;
    enc_idx = enc_off[IDX_W-1:0];

    enc_desc.sym_val = '0;
    enc_desc.sym_cnt = 4'd0;
    enc_desc.tail0   = '{ch: CH_SLASH, err: 1'b0};
    enc_desc.tail1   = '{ch: CH_SPACE, err: 1'b0};
    enc_desc.tail_cnt = 2'd2;
    if (enc_hit) begin
      enc_desc.sym_val  = SYM_VALUE[enc_idx];
      enc_desc.sym_cnt  = SYM_LENGTH[enc_idx];
      enc_desc.tail0    = '{ch: CH_SPACE, err: 1'b0};
      enc_desc.tail_cnt = 2'd1;
    end
  end

  // Decode path: shift in a symbol, then flush on space or end of message.
  logic                     is_sym;
  logic                     is_slash;
  logic [MAX_CODE_BITS-1:0] bits1;
  logic [CNT_W-1:0]         count1;
  logic                     ovf1;
  logic                     pending1;
  logic                     flush;
  logic [TABLE_SIZE-1:0]    match;
  logic [IDX_W-1:0]         lk_idx;
  logic                     lk_hit;
  res_t                     flush_res;

  always_comb begin
    is_sym   = (in_char == CH_ZERO) || (in_char == CH_ONE);
    is_slash = (in_char == CH_SLASH);
    bits1    = code_bits_r;
    count1   = code_count_r;
    ovf1     = code_ovf_r;
    if (is_sym) begin
      if (code_count_r >= CNT_W'(MAX_CODE_BITS)) begin
        ovf1 = 1'b1;
      end else begin
        // '0' and '1' differ only in bit 0
        bits1  = {code_bits_r[MAX_CODE_BITS-2:0], in_char[0]};
        count1 = code_count_r + CNT_W'(1);
      end
    end
    pending1 = (count1 != '0) || ovf1;
    // a space flush leaves nothing pending, so end of message adds no second one
    flush    = pending1 && ((in_char == CH_SPACE) || in_end_of_message);
  end

  // Match the collected code against every table entry at once.
  always_comb begin
    for (int i = 0; i < TABLE_SIZE; i++) begin
      match[i] = (count1 == CNT_W'(SYM_LENGTH[i])) &&
                 (bits1 == MAX_CODE_BITS'(SYM_VALUE[i]));
    end
    lk_idx = '0;
    for (int i = TABLE_SIZE - 1; i >= 0; i--) begin
      if (match[i]) begin
        lk_idx = IDX_W'(i);
      end
    end
    lk_hit = (|match) && !ovf1;
    if (lk_hit) begin
      flush_res = '{ch: 8'(FIRST_CHAR + {2'b00, lk_idx}), err: 1'b0};
    end else begin
      flush_res = '{ch: CH_NUL, err: 1'b1};
    end
  end

  always_comb begin
    dec_desc.sym_val = '0;
    dec_desc.sym_cnt = 4'd0;
    dec_desc.tail1   = flush_res;
    if (is_slash) begin
      // word space goes out ahead of any flushed character
      dec_desc.tail0    = '{ch: CH_SPACE, err: 1'b0};
      dec_desc.tail_cnt = flush ? 2'd2 : 2'd1;
    end else begin
      dec_desc.tail0    = flush_res;
      dec_desc.tail_cnt = flush ? 2'd1 : 2'd0;
    end

    code_bits_nxt  = code_bits_r;
    code_count_nxt = code_count_r;
    code_ovf_nxt   = code_ovf_r;
    if (accept && !mode_r) begin
      if (flush) begin
        code_bits_nxt  = '0;
        code_count_nxt = '0;
        code_ovf_nxt   = 1'b0;
      end else begin
        code_bits_nxt  = bits1;
        code_count_nxt = count1;
        code_ovf_nxt   = ovf1;
      end
    end
  end

  // Hand the result list to the serializer; items without results just drop.
  assign desc     = mode_r ? enc_desc : dec_desc;
  assign accept   = in_valid && emit_ready;
  assign load     = accept && ((desc.sym_cnt != 4'd0) || (desc.tail_cnt != 2'd0));
  assign in_stall = !emit_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= 1'b0;
      code_bits_r  <= '0;
      code_count_r <= '0;
      code_ovf_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        mode_r <= cfg_wr_data;
      end
      code_bits_r  <= code_bits_nxt;
      code_count_r <= code_count_nxt;
      code_ovf_r   <= code_ovf_nxt;
    end
  end

  mcc_emit u_emit (
    .clk            (clk),
    .rst_n          (rst_n),
    .load           (load),
    .desc           (desc),
    .ready          (emit_ready),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_char       (out_char),
    .out_code_error (out_code_error),
    .out_last       (out_last)
  );

endmodule

`default_nettype wire

[hw/rtl/mcc_checker.sv]
`default_nettype none

`include "morse_code_codec_defines.svh"

module mcc_checker import mcc_pkg::*; (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] out_char,
  input wire logic       out_code_error,
  input wire logic       out_last
);

  logic [9:0] out_word;
  logic       mid_ok;

  assign out_word = {out_char, out_code_error, out_last};
  assign mid_ok   = !out_code_error &&
                    (out_char inside {CH_ZERO, CH_ONE, CH_SLASH, CH_SPACE});

  // Hold a stalled result.
  `MCC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_word))

  // An error result ends its transfer's list and carries a null character.
  `MCC_ASSERT_NOW(a_err_form, out_valid && out_code_error, out_last && (out_char == CH_NUL))

  // Only symbols, slash or space come ahead of the final result.
  `MCC_ASSERT_NOW(a_mid_char, out_valid && !out_last, mid_ok)

endmodule

bind morse_code_codec mcc_checker u_mcc_checker (.*);

`default_nettype wire
